// ===== sv/avp_pkg.sv =====
// ----------------------------------------------------------------------------
// AVC444 view packer package
// Shared types, codes and the pixel colour conversion.
// ----------------------------------------------------------------------------
package avp_pkg;

  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;
  localparam int PaddrW       = 5;

  typedef struct packed {
    logic        mode;
    logic [7:0]  pix_x;
    logic [7:0]  pix_y;
    logic [23:0] pixel;
    logic        view;
    logic        plane;
    logic [7:0]  out_row;
    logic [7:0]  out_col;
  } in_t;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] status;
  } out_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_RANGE  = 2'd1,
    STATUS_NO_AUX = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    COMP_Y = 2'd0,
    COMP_U = 2'd1,
    COMP_V = 2'd2
  } comp_e;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_ALIGN  = 3'd2,
    REG_V2     = 3'd3,
    REG_MAIN   = 3'd4
  } reg_e;

  localparam logic MODE_WRITE = 1'b0;

  // Full-range BT.709 conversion with floor shift and clamping.
  function automatic logic [7:0] rgb_to_comp(input logic [23:0] rgb, input comp_e k);
    logic signed [18:0] r, g, b, s, q;
    r = signed'({11'd0, rgb[23:16]});
    g = signed'({11'd0, rgb[15:8]});
    b = signed'({11'd0, rgb[7:0]});
    case (k)
      COMP_U:  s = 19'sd128 * b - 19'sd29 * r - 19'sd99 * g;
      COMP_V:  s = 19'sd128 * r - 19'sd116 * g - 19'sd12 * b;
      default: s = 19'sd54 * r + 19'sd183 * g + 19'sd18 * b;
    endcase
    q = s >>> 8;
    if (k != COMP_Y) q = q + 19'sd128;
    if (q < 0) return 8'd0;
    if (q > 19'sd255) return 8'd255;
    return q[7:0];
  endfunction

endpackage

// ===== sv/avc444_view_packer.sv =====
// ----------------------------------------------------------------------------
// AVC444 view packer
// Stores RGB pixels and returns bytes of the main and auxiliary NV12 views.
// ----------------------------------------------------------------------------
// Write words are taken every cycle and stored at the edge that accepts them.
// A read word holds off the input until its result word is offered: it fetches
// one pixel for a point sample and four for a 2x2 average, as the single-port
// frame memory gives one pixel a cycle. An error read or an empty band line
// fetches nothing. Reset clears the control state and the registers to their
// defaults, not the frame memory.
module avc444_view_packer #(
  parameter int MAX_WIDTH  = avp_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = avp_pkg::MaxHeightDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [avp_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  avp_pkg::in_t               in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output avp_pkg::out_t              out_o
);
  import avp_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam logic [AW-1:0] RowStride = AW'(MAX_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  // configuration registers
  logic [8:0] width_q, height_q;
  logic       align_q, v2_q, main_q;

  function automatic logic [8:0] sat_size(input logic [8:0] v, input int mx);
    if (v == 9'd0) return 9'd1;
    if (int'(v) > mx) return 9'(mx);
    return v;
  endfunction

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd64;
      height_q <= 9'd64;
      align_q  <= 1'b0;
      v2_q     <= 1'b0;
      main_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_WIDTH:  width_q  <= sat_size(pwdata[8:0], MAX_WIDTH);
        REG_HEIGHT: height_q <= sat_size(pwdata[8:0], MAX_HEIGHT);
        REG_ALIGN:  align_q  <= pwdata[0];
        REG_V2:     v2_q     <= pwdata[0];
        REG_MAIN:   main_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_WIDTH:  prdata = {23'd0, width_q};
      REG_HEIGHT: prdata = {23'd0, height_q};
      REG_ALIGN:  prdata = {31'd0, align_q};
      REG_V2:     prdata = {31'd0, v2_q};
      REG_MAIN:   prdata = {31'd0, main_q};
      default:    prdata = 32'd0;
    endcase
  end

  // coded sizes
  logic [9:0] cw, ch;
  assign cw = align_q ? ((10'(width_q) + 10'd31) & ~10'd31)
                      : ((10'(width_q) + 10'd15) & ~10'd15);
  assign ch = (10'(height_q) + 10'd15) & ~10'd15;

  // ---------------------------------------------------------------- decode
  logic [1:0]  dec_status;
  logic [10:0] dec_x, dec_y;
  comp_e       dec_comp;
  logic        dec_avg, dec_none;
  logic [7:0]  row, col;
  logic [9:0]  src, yb, m;
  logic [4:0]  hb;
  logic [3:0]  rr;

  assign row = in_i.out_row;
  assign col = in_i.out_col;

  always_comb begin
    dec_status = STATUS_OK;
    dec_x      = 11'd0;
    dec_y      = 11'd0;
    dec_comp   = COMP_Y;
    dec_avg    = 1'b0;
    dec_none   = 1'b0;
    m          = 10'(height_q) - 10'd1;
    hb         = m[8:4];
    rr         = m[3:0];
    src        = {2'd0, row[7:4], 4'd0} + {6'd0, row[2:0], 1'b1};
    yb         = {2'd0, row};
    if (in_i.view && main_q) begin
      dec_status = STATUS_NO_AUX;
    end else if ({2'd0, col} >= cw ||
                 {2'd0, row} >= (in_i.plane ? {1'b0, ch[9:1]} : ch)) begin
      dec_status = STATUS_RANGE;
    end else if (!in_i.view) begin
      if (!in_i.plane) begin
        dec_x = {3'd0, col};
        dec_y = {3'd0, row};
      end else begin
        dec_comp = col[0] ? COMP_V : COMP_U;
        dec_x    = {3'd0, col[7:1], 1'b0};
        dec_y    = {2'd0, row, 1'b0};
        dec_avg  = v2_q || main_q;
      end
    end else if (!v2_q) begin
      if (!in_i.plane) begin
        // An undecodable row falls back to the last earlier line whose source
        // row lies inside the picture. Only the band holding the last picture
        // row can be partly valid, so the fallback lies in the same half of
        // that band, or else at the end of the band before it.
        if (src >= 10'(height_q)) begin
          if (rr != 4'd0) begin
            yb = {1'b0, hb, row[3], 3'd0} + {7'd0, 3'((rr - 4'd1) >> 1)};
          end else if (hb != 5'd0) begin
            yb = {1'b0, hb, 4'd0} - 10'd1;
          end else begin
            dec_none = 1'b1;
          end
        end
        dec_comp = yb[3] ? COMP_V : COMP_U;
        dec_x    = {3'd0, col};
        dec_y    = {1'b0, yb[9:4], 4'd0} + {7'd0, yb[2:0], 1'b1};
      end else begin
        dec_comp = col[0] ? COMP_V : COMP_U;
        dec_x    = {3'd0, col[7:1], 1'b1};
        dec_y    = {2'd0, row, 1'b0};
      end
    end else begin
      if (!in_i.plane) begin
        dec_y = {3'd0, row};
        if ({2'd0, col} < {1'b0, cw[9:1]}) begin
          dec_comp = COMP_U;
          dec_x    = {2'd0, col, 1'b1};
        end else begin
          dec_comp = COMP_V;
          dec_x    = {10'({2'd0, col} - {1'b0, cw[9:1]}), 1'b1};
        end
      end else begin
        dec_y = {2'd0, row, 1'b1};
        if ({3'd0, col[7:1]} < {2'd0, cw[9:2]}) begin
          dec_comp = COMP_U;
          dec_x    = {2'd0, col[7:1], 2'd0} + {9'd0, col[0], 1'b0};
        end else begin
          dec_comp = COMP_V;
          dec_x    = {1'b0, 8'({3'd0, col[7:1]} - {2'd0, cw[9:2]}), 2'd0}
                   + {9'd0, col[0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------- control
  state_e      state_q, state_d;
  logic [10:0] x0_q, y0_q;
  comp_e       comp_q;
  logic        avg_q, pend_q;
  logic [2:0]  iss_q, num_q;
  logic [9:0]  acc_q;
  logic [1:0]  st_q;
  logic [23:0] rdata_q;
  logic        out_valid_q;
  out_t        out_q;

  logic in_acc, rd_acc, issue;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign rd_acc     = in_acc && (in_i.mode != MODE_WRITE);
  assign issue      = (state_q == S_RUN) && (iss_q != num_q);

  // address of the pixel being fetched, with edge replication
  logic [10:0] px, py;
  logic [8:0]  sx, sy;
  logic [AW-1:0] raddr, waddr;
  assign px = x0_q + {10'd0, avg_q & iss_q[0]};
  assign py = y0_q + {10'd0, avg_q & iss_q[1]};
  assign sx = (px >= {2'd0, width_q})  ? width_q - 9'd1  : px[8:0];
  assign sy = (py >= {2'd0, height_q}) ? height_q - 9'd1 : py[8:0];
  assign raddr = AW'(sy) * RowStride + AW'(sx);
  assign waddr = AW'(in_i.pix_y) * RowStride + AW'(in_i.pix_x);

  logic mem_we;
  assign mem_we = in_acc && (in_i.mode == MODE_WRITE) &&
                  ({1'b0, in_i.pix_x} < width_q) && ({1'b0, in_i.pix_y} < height_q);

  logic [23:0] frame_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[waddr] <= in_i.pixel;
    end else if (issue) begin
      rdata_q <= frame_mem[raddr];
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (rd_acc) begin
        state_d = (dec_status != STATUS_OK || dec_none) ? S_FIN : S_RUN;
      end
      S_RUN:  if (!issue && !pend_q) begin
        state_d = S_FIN;
      end
      S_FIN:  if (out_free) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      iss_q       <= 3'd0;
      num_q       <= 3'd0;
    end else begin
      state_q <= state_d;
      pend_q  <= issue;
      if (issue) iss_q <= iss_q + 3'd1;
      if (rd_acc) begin
        iss_q <= 3'd0;
        num_q <= dec_avg ? 3'd4 : 3'd1;
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_acc) begin
      x0_q   <= dec_x;
      y0_q   <= dec_y;
      comp_q <= dec_comp;
      avg_q  <= dec_avg;
      st_q   <= dec_status;
      acc_q  <= 10'd0;
    end else if (pend_q) begin
      acc_q <= acc_q + {2'd0, rgb_to_comp(rdata_q, comp_q)};
    end
    if (state_q == S_FIN && out_free) begin
      out_q.status <= st_q;
      out_q.value  <= avg_q ? 8'(({1'b0, acc_q} + 11'd2) >> 2) : acc_q[7:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== sv/avp_checker.sv =====
// ----------------------------------------------------------------------------
// AVC444 view packer port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module avp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input avp_pkg::in_t  in_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input avp_pkg::out_t out_o
);
  import avp_pkg::*;

  // A waiting result word stays on offer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result word dropped while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != STATUS_OK |-> out_o.value == 8'd0)
    else $error("error result carries a non-zero byte");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.status != 2'd3)
    else $error("undefined status code");

  // A read word occupies the block for at least the next cycle.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_i.mode != MODE_WRITE |=> !in_ready_o)
    else $error("read word did not hold off the input");

endmodule

bind avc444_view_packer avp_checker u_avp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// AVC444 view packer testbench
// Writes random frames, reads bytes of every view and plane under several
// size and layout settings, and checks each answer against a predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import avp_pkg::*;

  localparam int InW = $bits(in_t);

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t in_word;
  out_t out_word;

  avc444_view_packer dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_o(out_word)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Predictor state: a copy of the frame and the registers.
  logic [23:0] frame_copy [0:65535];
  int unsigned pic_w, pic_h;
  bit align32, layout_v2, main_view;
  out_t answers_due[$];
  int errors;
  int send_idle_pct, recv_idle_pct;
  bit recv_hold;

  function automatic logic [7:0] to_comp(logic [23:0] p, comp_e k);
    int r, g, b, s, q;
    r = p[23:16]; g = p[15:8]; b = p[7:0];
    case (k)
      COMP_Y:  s = 54*r + 183*g + 18*b;
      COMP_U:  s = -29*r - 99*g + 128*b;
      default: s = 128*r - 116*g - 12*b;
    endcase
    q = (s >= 0) ? (s >>> 8) : -((-s + 255) >>> 8);
    if (k != COMP_Y) q = q + 128;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic logic [7:0] sample(int unsigned sx, int unsigned sy, comp_e k);
    if (sx >= pic_w) sx = pic_w - 1;
    if (sy >= pic_h) sy = pic_h - 1;
    return to_comp(frame_copy[sy*256 + sx], k);
  endfunction

  function automatic out_t predict_byte(in_t w);
    out_t o;
    int unsigned cw, ch, c, s, y, src, odd, row, col;
    comp_e k;
    o.value = 8'd0;
    o.status = STATUS_OK;
    row = w.out_row; col = w.out_col;
    cw = align32 ? ((pic_w + 31) & ~31) : ((pic_w + 15) & ~15);
    ch = (pic_h + 15) & ~15;
    if (w.view && main_view) begin
      o.status = STATUS_NO_AUX;
      return o;
    end
    if (col >= cw || row >= (w.plane ? ch/2 : ch)) begin
      o.status = STATUS_RANGE;
      return o;
    end
    c = col >> 1;
    k = col[0] ? COMP_V : COMP_U;
    if (!w.view) begin
      if (!w.plane) o.value = sample(col, row, COMP_Y);
      else if (layout_v2 || main_view) begin
        s = sample(2*c, 2*row, k) + sample(2*c+1, 2*row, k)
          + sample(2*c, 2*row+1, k) + sample(2*c+1, 2*row+1, k);
        o.value = 8'((s + 2) / 4);
      end else o.value = sample(2*c, 2*row, k);
    end else if (!layout_v2) begin
      if (!w.plane) begin
        // Undecodable band rows fall back to the nearest earlier valid line.
        y = row;
        forever begin
          src = 2*(8*(y >> 4) + (y & 7)) + 1;
          if (src < pic_h) begin
            o.value = sample(col, src, ((y & 15) < 8) ? COMP_U : COMP_V);
            break;
          end
          if (y == 0) break;
          y--;
        end
      end else o.value = sample(2*c+1, 2*row, k);
    end else begin
      if (!w.plane) begin
        if (col < cw/2) o.value = sample(2*col+1, row, COMP_U);
        else o.value = sample(2*(col - cw/2)+1, row, COMP_V);
      end else begin
        odd = col & 1;
        if (c < cw/4) o.value = sample(4*c + 2*odd, 2*row+1, COMP_U);
        else o.value = sample(4*(c - cw/4) + 2*odd, 2*row+1, COMP_V);
      end
    end
    return o;
  endfunction

  // Leaves valid high after the word is taken; the next word or drain drops it.
  task automatic send_word(in_t w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.mode == MODE_WRITE) begin
      if (w.pix_x < pic_w && w.pix_y < pic_h) frame_copy[w.pix_y*256 + w.pix_x] = w.pixel;
    end else answers_due.push_back(predict_byte(w));
  endtask

  task automatic write_pixel(int x, int y, logic [23:0] p);
    in_t w;
    w = in_t'(InW'({$urandom(), $urandom()}));
    w.mode = MODE_WRITE; w.pix_x = 8'(x); w.pix_y = 8'(y); w.pixel = p;
    send_word(w);
  endtask

  task automatic read_byte(bit v, bit pl, int r, int c);
    in_t w;
    w = in_t'(InW'({$urandom(), $urandom()}));
    w.mode = ~MODE_WRITE; w.view = v; w.plane = pl; w.out_row = 8'(r); w.out_col = 8'(c);
    send_word(w);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(reg_e idx, int unsigned val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PaddrW'(4*idx); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic configure(int unsigned w, int unsigned h, bit a, bit v2, bit m);
    drain();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_ALIGN, a);
    reg_write(REG_V2, v2);
    reg_write(REG_MAIN, m);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    pic_w = (w & 9'h1ff) == 0 ? 1 : ((w & 9'h1ff) > 256 ? 256 : (w & 9'h1ff));
    pic_h = (h & 9'h1ff) == 0 ? 1 : ((h & 9'h1ff) > 256 ? 256 : (h & 9'h1ff));
    align32 = a; layout_v2 = v2; main_view = m;
  endtask

  // Fills the whole visible picture so no read touches an unwritten pixel.
  task automatic fill_frame(bit extremes);
    logic [23:0] p;
    for (int y = 0; y < pic_h; y++)
      for (int x = 0; x < pic_w; x++) begin
        p = 24'($urandom());
        if (extremes) p = (x + y) % 2 ? 24'hffffff : 24'h000000;
        write_pixel(x, y, p);
      end
  endtask

  task automatic random_reads(int n);
    int cw, ch;
    bit v, pl;
    cw = align32 ? ((pic_w + 31) & ~31) : ((pic_w + 15) & ~15);
    ch = (pic_h + 15) & ~15;
    repeat (n) begin
      v = $urandom_range(1); pl = $urandom_range(1);
      if ($urandom_range(9) == 0) read_byte(v, pl, $urandom_range(255), $urandom_range(255));
      else read_byte(v, pl, $urandom_range(pl ? ch/2 - 1 : ch - 1), $urandom_range(cw - 1));
    end
  endtask

  task automatic test_directed;
    configure(64, 64, 0, 0, 0);
    configure(4, 4, 0, 0, 0);
    // Colour extremes: pure primaries, secondaries, black and white.
    write_pixel(0, 0, 24'hff0000); write_pixel(1, 0, 24'h00ff00);
    write_pixel(0, 1, 24'h0000ff); write_pixel(1, 1, 24'hffffff);
    write_pixel(2, 0, 24'h000000); write_pixel(3, 0, 24'hff00ff);
    write_pixel(2, 1, 24'h00ffff); write_pixel(3, 1, 24'hffff00);
    for (int y = 2; y < 4; y++)
      for (int x = 0; x < 4; x++) write_pixel(x, y, 24'($urandom()));
    write_pixel(200, 1, 24'h123456);  // outside the picture, dropped
    read_byte(0, 0, 0, 0); read_byte(0, 0, 15, 15);
    read_byte(0, 1, 0, 0); read_byte(0, 1, 0, 1);
    read_byte(1, 0, 0, 0);  // band row 0: U samples of source row 1
    read_byte(1, 0, 9, 3);
    read_byte(1, 1, 1, 1); read_byte(0, 0, 16, 0);
    read_byte(0, 1, 8, 0); read_byte(1, 0, 0, 255);
    configure(4, 4, 1, 1, 1);
    read_byte(1, 0, 0, 0);  // no aux view in main-only mode
    read_byte(0, 1, 0, 3); read_byte(0, 0, 255, 255);
    configure(4, 4, 0, 1, 0);
    read_byte(1, 0, 3, 9); read_byte(1, 1, 1, 2);
  endtask

  task automatic test_sizes;
    configure(0, 0, 0, 0, 0);  // zero taken as one
    fill_frame(0);
    random_reads(20);
    configure(9'h1ff, 1, 1, 0, 0);  // saturates to the maximum width
    fill_frame(1);
    random_reads(40);
    configure(4, 33, 0, 0, 1);
    fill_frame(0);
    random_reads(40);
  endtask

  task automatic test_layouts;
    for (int i = 0; i < 3; i++) begin
      configure($urandom_range(1, 6), $urandom_range(1, 36),
                $urandom_range(1), $urandom_range(1), $urandom_range(1));
      fill_frame(0);
      random_reads(20);
    end
  endtask

  task automatic test_backpressure;
    configure(8, 8, 0, 1, 0);
    fill_frame(0);
    recv_hold = 1'b1;
    fork
      begin repeat (300) @(posedge clk); recv_hold = 1'b0; end
      random_reads(40);
    join
    drain();  // sender pauses until every byte is back
    random_reads(40);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected word value=%0d status=%0d", $time,
                   out_word.value, out_word.status);
          errors++;
        end else begin
          out_t e;
          e = answers_due.pop_front();
          if (e.value !== out_word.value || e.status !== out_word.status) begin
            $display("%0t: mismatch expected value=%0d status=%0d got value=%0d status=%0d",
                     $time, e.value, e.status, out_word.value, out_word.status);
            errors++;
          end
        end
      end
      out_ready <= !recv_hold && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    errors = 0; recv_hold = 0;
    send_idle_pct = 6; recv_idle_pct = 77;
    rst_n = 1'b0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; in_word = '0; out_ready = 0;
    pic_w = 64; pic_h = 64; align32 = 0; layout_v2 = 0; main_view = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_sizes();
    send_idle_pct = 77; recv_idle_pct = 6;
    test_layouts();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_layouts();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

// ===== avc444_view_packer.f =====
sv/avp_pkg.sv
sv/avc444_view_packer.sv
sv/avp_checker.sv
tb/sv/testbench.sv
